FILE: rtl/cipsc_pkg.sv
// ----------------------------------------------------------------------------
// cipsc_pkg: shared types and constants of the complex postfix calculator
// Command codes, the complex word type and the cell shift commands.
// ----------------------------------------------------------------------------
package cipsc_pkg;

  // width of one real or imaginary part
  localparam int DATA_W = 32;

  // default number of stack entries
  localparam int STACK_DEPTH_DEF = 64;

  // command kinds
  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_BINARY = 2'd1,
    MODE_UNARY  = 2'd2,
    MODE_SHOW   = 2'd3
  } mode_t;

  // binary operators
  localparam logic [1:0] BIN_ADD = 2'd0;
  localparam logic [1:0] BIN_SUB = 2'd1;
  localparam logic [1:0] BIN_MUL = 2'd2;

  // unary operators
  localparam logic [1:0] UN_NEG  = 2'd0;
  localparam logic [1:0] UN_CONJ = 2'd1;

  // one complex value
  typedef struct packed {
    logic signed [DATA_W-1:0] im;
    logic signed [DATA_W-1:0] re;
  } complex_t;

  // what a cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_DOWN = 2'd1,   // take the value of the neighbor nearer the top
    CELL_UP   = 2'd2    // take the value of the neighbor deeper down
  } cell_cmd_t;

endpackage

FILE: rtl/cipsc_cell.sv
// ----------------------------------------------------------------------------
// cipsc_cell: one stack entry
// Holds one complex value and trades it with its neighbors on push and pop.
// ----------------------------------------------------------------------------
module cipsc_cell (
  input  logic                 clk,
  input  cipsc_pkg::cell_cmd_t cmd,
  input  cipsc_pkg::complex_t  up_data,   // neighbor toward the top
  input  cipsc_pkg::complex_t  dn_data,   // neighbor toward the bottom
  output cipsc_pkg::complex_t  value
);

  // entry register, undefined until first written
  always_ff @(posedge clk) begin
    case (cmd)
      cipsc_pkg::CELL_DOWN: value <= up_data;
      cipsc_pkg::CELL_UP:   value <= dn_data;
      default:              value <= value;
    endcase
  end

endmodule

FILE: rtl/cipsc_alu.sv
// ----------------------------------------------------------------------------
// cipsc_alu: complex arithmetic unit
// Add, subtract, negate and conjugate are combinational; multiply registers its
// four partial products and combines them in the following cycle.
// ----------------------------------------------------------------------------
module cipsc_alu (
  input  logic                clk,
  input  cipsc_pkg::mode_t    mode,
  input  logic [1:0]          op_code,
  input  cipsc_pkg::complex_t x,        // entry below the top
  input  cipsc_pkg::complex_t y,        // top entry
  output cipsc_pkg::complex_t res,      // combinational result
  output cipsc_pkg::complex_t mul_res   // product, valid the cycle after its operands
);

  logic [cipsc_pkg::DATA_W-1:0] p_rr, p_ii, p_ri, p_ir;

  // combinational operations
  always_comb begin
    res = y;
    if (mode == cipsc_pkg::MODE_BINARY) begin
      if (op_code == cipsc_pkg::BIN_SUB) begin
        res.re = x.re - y.re;
        res.im = x.im - y.im;
      end else begin
        res.re = x.re + y.re;
        res.im = x.im + y.im;
      end
    end else begin
      if (op_code == cipsc_pkg::UN_NEG) begin
        res.re = -y.re;
        res.im = -y.im;
      end else begin
        res.re = y.re;
        res.im = -y.im;
      end
    end
  end

  // partial products, low word only (wraps like the integer result)
  always_ff @(posedge clk) begin
    p_rr <= x.re * y.re;
    p_ii <= x.im * y.im;
    p_ri <= x.re * y.im;
    p_ir <= x.im * y.re;
  end

  // combine products
  assign mul_res.re = p_rr - p_ii;
  assign mul_res.im = p_ri + p_ir;

endmodule

FILE: rtl/complex_integer_postfix_stack_calculator.sv
// ----------------------------------------------------------------------------
// complex_integer_postfix_stack_calculator: postfix calculator, complex ints
// Stack of complex values built as a row of shifting cells, with a small
// command sequencer and a complex arithmetic unit.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_ group: s_tuser carries the command kind (push,
//   binary, unary, show), s_tdata the operator and the value to push. Only a
//   show returns a transfer on the m_ group: the top value, an empty flag and
//   the sticky error flag.
//   Each command is accepted, then executed; a multiply, an unknown binary
//   operator and a show pass through a further state (S_MUL, S_SHIFT,
//   S_SHOW), since the products are registered, a drop of two entries shifts
//   the cell row twice and a show then loads the output register.
//   A show passes through S_EXEC and S_SHOW before m_tvalid rises.
//   The result sits in an output register, so later commands go on while it
//   waits. A second show while the first is still unread waits in the
//   sequencer until m_tready drains the register.
//   Underflow or overflow leaves the stack unchanged and sets the sticky error
//   flag. Reset empties the stack, clears the flag and drops a pending result;
//   the entries themselves are not cleared.
// ----------------------------------------------------------------------------
module complex_integer_postfix_stack_calculator #(
  parameter int STACK_DEPTH = cipsc_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,    // op_code[1:0], real_part[33:2], imag_part[65:34], zero
  input  logic [1:0]  s_tuser,    // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,    // top_real[31:0], top_imag[63:32]
  output logic [1:0]  m_tuser     // stack_empty[0], error_seen[1]
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_MUL   = 5'b00100,
    S_SHIFT = 5'b01000,
    S_SHOW  = 5'b10000
  } state_t;

  state_t                  state, state_next;
  cipsc_pkg::mode_t        cmd_mode;
  logic [1:0]              cmd_op;
  cipsc_pkg::complex_t     cmd_val;
  logic [CNT_W-1:0]        count, count_next;
  logic                    err, err_next;
  cipsc_pkg::cell_cmd_t    cmd_top, cmd_rest;
  cipsc_pkg::complex_t     top_in;
  cipsc_pkg::complex_t     alu_res, mul_res;
  cipsc_pkg::complex_t     cells [STACK_DEPTH];
  logic                    out_load;

  assign s_tready = (state == S_IDLE);

  // latch the accepted command
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_mode   <= cipsc_pkg::mode_t'(s_tuser);
      cmd_op     <= s_tdata[1:0];
      cmd_val.re <= s_tdata[33:2];
      cmd_val.im <= s_tdata[65:34];
    end
  end

  // arithmetic on the two top entries
  cipsc_alu u_alu (
    .clk     (clk),
    .mode    (cmd_mode),
    .op_code (cmd_op),
    .x       (cells[1]),
    .y       (cells[0]),
    .res     (alu_res),
    .mul_res (mul_res)
  );

  // sequencer: decides the cell commands and the new count
  always_comb begin
    state_next = state;
    count_next = count;
    err_next   = err;
    cmd_top    = cipsc_pkg::CELL_HOLD;
    cmd_rest   = cipsc_pkg::CELL_HOLD;
    top_in     = cmd_val;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
        case (cmd_mode)
          cipsc_pkg::MODE_PUSH: begin
            if (count == FULL) begin
              err_next = 1'b1;
            end else begin
              cmd_top    = cipsc_pkg::CELL_DOWN;
              cmd_rest   = cipsc_pkg::CELL_DOWN;
              count_next = count + 1'b1;
            end
          end
          cipsc_pkg::MODE_BINARY: begin
            if (count < CNT_W'(2)) begin
              err_next = 1'b1;
            end else if (cmd_op == cipsc_pkg::BIN_MUL) begin
              state_next = S_MUL;
            end else if (cmd_op == cipsc_pkg::BIN_ADD || cmd_op == cipsc_pkg::BIN_SUB) begin
              // pop two, push one: result on top, rest moves up by one
              top_in     = alu_res;
              cmd_top    = cipsc_pkg::CELL_DOWN;
              cmd_rest   = cipsc_pkg::CELL_UP;
              count_next = count - 1'b1;
            end else begin
              // drop both: two single pops
              cmd_top    = cipsc_pkg::CELL_UP;
              cmd_rest   = cipsc_pkg::CELL_UP;
              count_next = count - 1'b1;
              state_next = S_SHIFT;
            end
          end
          cipsc_pkg::MODE_UNARY: begin
            if (count == '0) begin
              err_next = 1'b1;
            end else if (cmd_op == cipsc_pkg::UN_NEG || cmd_op == cipsc_pkg::UN_CONJ) begin
              top_in  = alu_res;
              cmd_top = cipsc_pkg::CELL_DOWN;
            end else begin
              cmd_top    = cipsc_pkg::CELL_UP;
              cmd_rest   = cipsc_pkg::CELL_UP;
              count_next = count - 1'b1;
            end
          end
          default: begin
            state_next = S_SHOW;
          end
        endcase
      end
      S_MUL: begin
        top_in     = mul_res;
        cmd_top    = cipsc_pkg::CELL_DOWN;
        cmd_rest   = cipsc_pkg::CELL_UP;
        count_next = count - 1'b1;
        state_next = S_IDLE;
      end
      S_SHIFT: begin
        cmd_top    = cipsc_pkg::CELL_UP;
        cmd_rest   = cipsc_pkg::CELL_UP;
        count_next = count - 1'b1;
        state_next = S_IDLE;
      end
      S_SHOW: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      err   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      err   <= err_next;
    end
  end

  // row of stack cells, entry 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    cipsc_pkg::complex_t up_d, dn_d;
    if (i == 0) begin : g_top
      assign up_d = top_in;
    end else begin : g_mid
      assign up_d = cells[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign dn_d = '0;
    end else begin : g_nxt
      assign dn_d = cells[i+1];
    end
    cipsc_cell u_cell (
      .clk     (clk),
      .cmd     ((i == 0) ? cmd_top : cmd_rest),
      .up_data (up_d),
      .dn_data (dn_d),
      .value   (cells[i])
    );
  end

  // output register for show results
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (count == '0) begin
        m_tdata    <= '0;
        m_tuser[0] <= 1'b1;
      end else begin
        m_tdata    <= {cells[0].im, cells[0].re};
        m_tuser[0] <= 1'b0;
      end
      m_tuser[1] <= err;
    end
  end

endmodule
